[hw/rtl/chacha20_random_generator_macros.svh]
// Assertion helpers shared by the RTL files
`ifndef CHACHA20_RANDOM_GENERATOR_MACROS_SVH
`define CHACHA20_RANDOM_GENERATOR_MACROS_SVH

// Implication checked at every clock edge outside reset
`define CRG_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent
`define CRG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/crg_pkg.sv]
`default_nettype none

package crg_pkg;

    localparam int DOUBLE_ROUNDS_DEF = 10;
    localparam int BLOCK_BYTES = 64;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_WORD   = 2'd1,
        KIND_UNI    = 2'd2,
        KIND_RESEED = 2'd3
    } kind_t;

    localparam logic [1:0] REG_KEY01 = 2'd0;
    localparam logic [1:0] REG_KEY23 = 2'd1;
    localparam logic [1:0] REG_KEY45 = 2'd2;
    localparam logic [1:0] REG_KEY67 = 2'd3;

    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;

    // classified request handed from front to back
    typedef struct packed {
        kind_t       kind;
        logic        pow2;
        logic        zero;
        logic [31:0] bound;
    } req_t;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

endpackage

`default_nettype wire

[hw/rtl/crg_front.sv]
`default_nettype none

// Accepts requests, classifies them and queues them for the back end.
module crg_front
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         in_kind,
    input  wire logic [31:0]        in_bound,
    output logic                    q_valid,
    input  wire logic               q_pop,
    output crg_pkg::req_t           q_req
);

    crg_pkg::req_t q_mem [crg_pkg::QUEUE_DEPTH];
    logic [$clog2(crg_pkg::QUEUE_DEPTH)-1:0] wr_reg, rd_reg;
    logic [$clog2(crg_pkg::QUEUE_DEPTH):0]   cnt_reg;
    crg_pkg::req_t in_req;
    logic push;

    always_comb
    begin
        in_req.kind  = crg_pkg::kind_t'(in_kind);
        in_req.bound = in_bound;
        in_req.zero  = (in_bound == 32'd0);
        in_req.pow2  = ((in_bound & (in_bound - 32'd1)) == 32'd0);
    end

    assign in_ready = (cnt_reg != ($clog2(crg_pkg::QUEUE_DEPTH)+1)'(crg_pkg::QUEUE_DEPTH));
    assign push = in_valid && in_ready;
    assign q_valid = (cnt_reg != '0);
    assign q_req = q_mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_reg] <= in_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + ($clog2(crg_pkg::QUEUE_DEPTH)+1)'(push)
                               - ($clog2(crg_pkg::QUEUE_DEPTH)+1)'(q_pop);
        end
    end

`include "chacha20_random_generator_macros.svh"
    `CRG_ASSERT_IMP(a_no_pop_empty, q_pop, q_valid, "pop from empty queue")
    `CRG_ASSERT_IMP(a_cnt_range, 1'b1,
        cnt_reg <= ($clog2(crg_pkg::QUEUE_DEPTH)+1)'(crg_pkg::QUEUE_DEPTH),
        "queue count overflow")
    `CRG_ASSERT_NEXT(a_push_grows, push && !q_pop, cnt_reg == $past(cnt_reg) + 1'b1,
        "queue count did not grow on push")

endmodule

`default_nettype wire

[hw/rtl/crg_core.sv]
`default_nettype none

// ChaCha block function: one quarter round per cycle on a shared unit.
module crg_core
#(
    parameter int DOUBLE_ROUNDS = crg_pkg::DOUBLE_ROUNDS_DEF
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [255:0]  key,
    input  wire logic [63:0]   counter,
    output logic               done,
    output logic [511:0]       block
);

    localparam int QR_TOTAL = 8 * DOUBLE_ROUNDS;
    localparam int QW = $clog2(QR_TOTAL + 1);

    logic [31:0] work_reg [16];
    logic [31:0] init_reg [16];
    logic [QW-1:0] qr_reg;
    logic busy_reg;
    logic [3:0] ia, ib, ic, id;
    logic [31:0] a0, b0, c0, d0, a1, b1, c1, d1, a2, b2, c2, d2;
    logic [2:0] sel;

    assign sel = qr_reg[2:0];

    always_comb
    begin
        case (sel)
            3'd0: begin ia = 4'd0; ib = 4'd4; ic = 4'd8;  id = 4'd12; end
            3'd1: begin ia = 4'd1; ib = 4'd5; ic = 4'd9;  id = 4'd13; end
            3'd2: begin ia = 4'd2; ib = 4'd6; ic = 4'd10; id = 4'd14; end
            3'd3: begin ia = 4'd3; ib = 4'd7; ic = 4'd11; id = 4'd15; end
            3'd4: begin ia = 4'd0; ib = 4'd5; ic = 4'd10; id = 4'd15; end
            3'd5: begin ia = 4'd1; ib = 4'd6; ic = 4'd11; id = 4'd12; end
            3'd6: begin ia = 4'd2; ib = 4'd7; ic = 4'd8;  id = 4'd13; end
            default: begin ia = 4'd3; ib = 4'd4; ic = 4'd9; id = 4'd14; end
        endcase
        a0 = work_reg[ia] + work_reg[ib];
        d0 = crg_pkg::rotl(work_reg[id] ^ a0, 16);
        c0 = work_reg[ic] + d0;
        b0 = crg_pkg::rotl(work_reg[ib] ^ c0, 12);
        a1 = a0 + b0;
        d1 = crg_pkg::rotl(d0 ^ a1, 8);
        c1 = c0 + d1;
        b1 = crg_pkg::rotl(b0 ^ c1, 7);
        a2 = a1; b2 = b1; c2 = c1; d2 = d1;
    end

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            block[32*i +: 32] = work_reg[i] + init_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            init_reg[0] <= crg_pkg::SIGMA0;
            init_reg[1] <= crg_pkg::SIGMA1;
            init_reg[2] <= crg_pkg::SIGMA2;
            init_reg[3] <= crg_pkg::SIGMA3;
            work_reg[0] <= crg_pkg::SIGMA0;
            work_reg[1] <= crg_pkg::SIGMA1;
            work_reg[2] <= crg_pkg::SIGMA2;
            work_reg[3] <= crg_pkg::SIGMA3;
            for (int i = 0; i < 8; i++)
            begin
                init_reg[4+i] <= key[32*i +: 32];
                work_reg[4+i] <= key[32*i +: 32];
            end
            init_reg[12] <= counter[31:0];
            init_reg[13] <= counter[63:32];
            init_reg[14] <= 32'd0;
            init_reg[15] <= 32'd0;
            work_reg[12] <= counter[31:0];
            work_reg[13] <= counter[63:32];
            work_reg[14] <= 32'd0;
            work_reg[15] <= 32'd0;
        end
        else if (busy_reg)
        begin
            work_reg[ia] <= a2;
            work_reg[ib] <= b2;
            work_reg[ic] <= c2;
            work_reg[id] <= d2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            qr_reg   <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                qr_reg   <= '0;
            end
            else if (busy_reg)
            begin
                if (qr_reg == QW'(QR_TOTAL - 1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
                qr_reg <= qr_reg + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/crg_back.sv]
`default_nettype none

// Executes queued requests: reseed, byte fetch, refill, rejection, modulo, output.
module crg_back
#(
    parameter int DOUBLE_ROUNDS = crg_pkg::DOUBLE_ROUNDS_DEF
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    output logic               q_pop,
    input  crg_pkg::req_t      q_req,
    input  wire logic [255:0]  key,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [31:0]        out_value
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_BYTE  = 7'b0000010,
        S_FILL  = 7'b0000100,
        S_EVAL  = 7'b0001000,
        S_LIM   = 7'b0010000,
        S_MOD   = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg;
    logic [511:0] buf_reg;
    logic [6:0]   pos_reg;
    logic [63:0]  ctr_reg;
    logic [1:0]   nb_reg;
    logic [31:0]  word_reg, res_reg, lim_reg;
    logic         lim_ok_reg;
    crg_pkg::req_t req_reg;
    // restoring divider
    logic [31:0]  rem_reg, dvd_reg;
    logic [5:0]   div_cnt_reg;
    logic         div_for_lim_reg;
    logic [32:0]  rem_sh, rem_sub;
    logic         core_start, core_done;
    logic [511:0] core_block;
    logic [7:0]   cur_byte;
    logic [31:0]  word_next;

    crg_core #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (core_start),
        .key     (key),
        .counter (ctr_reg),
        .done    (core_done),
        .block   (core_block)
    );

    assign cur_byte  = buf_reg[{pos_reg[5:0], 3'b000} +: 8];
    assign word_next = {cur_byte, word_reg[31:8]};
    assign rem_sh  = {rem_reg, dvd_reg[31]};
    assign rem_sub = rem_sh - {1'b0, req_reg.bound};
    assign core_start = (state_reg == S_BYTE) && pos_reg[6];
    assign q_pop = (state_reg == S_IDLE) && q_valid && !out_valid;

    always_ff @(posedge clk)
    begin
        if (core_done)
        begin
            buf_reg <= core_block;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pos_reg    <= 7'd64;
            ctr_reg    <= '0;
            out_valid  <= 1'b0;
            out_value  <= '0;
            nb_reg     <= '0;
            word_reg   <= '0;
            res_reg    <= '0;
            lim_reg    <= '0;
            lim_ok_reg <= 1'b0;
            req_reg    <= '0;
            rem_reg    <= '0;
            dvd_reg    <= '0;
            div_cnt_reg <= '0;
            div_for_lim_reg <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                out_valid <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        req_reg    <= q_req;
                        nb_reg     <= '0;
                        lim_ok_reg <= 1'b0;
                        if (q_req.kind == crg_pkg::KIND_RESEED)
                        begin
                            ctr_reg <= '0;
                            pos_reg <= 7'd64;
                        end
                        else
                        begin
                            state_reg <= S_BYTE;
                        end
                    end
                end
                S_BYTE:
                begin
                    if (pos_reg[6])
                    begin
                        state_reg <= S_FILL;
                    end
                    else
                    begin
                        pos_reg  <= pos_reg + 7'd1;
                        word_reg <= word_next;
                        nb_reg   <= nb_reg + 2'd1;
                        if (req_reg.kind == crg_pkg::KIND_BYTE)
                        begin
                            res_reg   <= {24'd0, cur_byte};
                            state_reg <= S_OUT;
                        end
                        else if (nb_reg == 2'd3)
                        begin
                            state_reg <= S_EVAL;
                        end
                    end
                end
                S_FILL:
                begin
                    if (core_done)
                    begin
                        ctr_reg   <= ctr_reg + 64'd1;
                        pos_reg   <= 7'd0;
                        state_reg <= S_BYTE;
                    end
                end
                S_EVAL:
                begin
                    if (req_reg.kind == crg_pkg::KIND_WORD)
                    begin
                        res_reg   <= word_reg;
                        state_reg <= S_OUT;
                    end
                    else if (req_reg.zero)
                    begin
                        res_reg   <= '0;
                        state_reg <= S_OUT;
                    end
                    else if (req_reg.pow2)
                    begin
                        res_reg   <= word_reg & (req_reg.bound - 32'd1);
                        state_reg <= S_OUT;
                    end
                    else if (!lim_ok_reg)
                    begin
                        // limit = (2^32 - bound) mod bound, computed once
                        dvd_reg <= 32'd0 - req_reg.bound;
                        rem_reg <= '0;
                        div_cnt_reg <= '0;
                        div_for_lim_reg <= 1'b1;
                        state_reg <= S_MOD;
                    end
                    else if (word_reg < lim_reg)
                    begin
                        state_reg <= S_BYTE;
                    end
                    else
                    begin
                        dvd_reg <= word_reg;
                        rem_reg <= '0;
                        div_cnt_reg <= '0;
                        div_for_lim_reg <= 1'b0;
                        state_reg <= S_MOD;
                    end
                end
                S_MOD:
                begin
                    dvd_reg <= {dvd_reg[30:0], 1'b0};
                    rem_reg <= rem_sub[32] ? rem_sh[31:0] : rem_sub[31:0];
                    div_cnt_reg <= div_cnt_reg + 6'd1;
                    if (div_cnt_reg == 6'd31)
                    begin
                        state_reg <= S_LIM;
                    end
                end
                S_LIM:
                begin
                    if (div_for_lim_reg)
                    begin
                        lim_reg    <= rem_reg;
                        lim_ok_reg <= 1'b1;
                        state_reg  <= S_EVAL;
                    end
                    else
                    begin
                        res_reg   <= rem_reg;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid)
                    begin
                        out_valid <= 1'b1;
                        out_value <= res_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`include "chacha20_random_generator_macros.svh"
    `CRG_ASSERT_IMP(a_pos_range, 1'b1, pos_reg <= 7'd64, "byte position out of range")
    `CRG_ASSERT_NEXT(a_fill_sets_pos, (state_reg == S_FILL) && core_done,
        pos_reg == 7'd0, "refill did not reset position")
    `CRG_ASSERT_IMP(a_byte_small, out_valid && (req_reg.kind == crg_pkg::KIND_BYTE),
        out_value[31:8] == 24'd0, "byte result not zero-extended")

endmodule

`default_nettype wire

[hw/rtl/chacha20_random_generator.sv]
// ChaCha20 random source. Requests on s_axis (kind, bound) give a byte, a
// word or a uniform value below bound (0 for a zero bound) on m_axis; a
// reseed gives no result. Bytes and words come from the buffered block.
// The next request leaves the queue in the cycle after the result is
// taken, so only one request is in execution at a time. A block refill
// runs on one shared quarter-round unit, once per 64 bytes. A
// non-power-of-two bound adds two bit-serial remainder passes, and each
// rejected word is replaced by a fresh one. A two-entry request queue sits
// before the execution unit.
`default_nettype none

module chacha20_random_generator
#(
    parameter int DOUBLE_ROUNDS = crg_pkg::DOUBLE_ROUNDS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] bound
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] value
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    logic [63:0] key_reg [4];
    logic [255:0] key;
    logic q_valid, q_pop;
    crg_pkg::req_t q_req;

    assign key = {key_reg[3], key_reg[2], key_reg[1], key_reg[0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg[0] <= '0;
            key_reg[1] <= '0;
            key_reg[2] <= '0;
            key_reg[3] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                crg_pkg::REG_KEY01: key_reg[0] <= cfg_data;
                crg_pkg::REG_KEY23: key_reg[1] <= cfg_data;
                crg_pkg::REG_KEY45: key_reg[2] <= cfg_data;
                crg_pkg::REG_KEY67: key_reg[3] <= cfg_data;
                default: key_reg[0] <= key_reg[0];
            endcase
        end
    end

    crg_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_kind  (s_axis_tuser),
        .in_bound (s_axis_tdata),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_req    (q_req)
    );

    crg_back #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_req     (q_req),
        .key       (key),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_value (m_axis_tdata)
    );

endmodule

`default_nettype wire
